// ----- design/sslb_pkg.sv -----
// Package for the signed-sum lookup table builder.
// Holds the shared widths and constants; no dependencies.
`timescale 1ns / 1ps

package sslb_pkg;

    // Default activation width (signed, 8 fraction bits at 16 bits).
    localparam int ACT_BITS_DEF  = 16;

    // Activations per group and table entries per group.
    localparam int GROUP_SIZE    = 4;
    localparam int LUT_ENTRIES   = 1 << GROUP_SIZE;
    localparam int HALF_ENTRIES  = LUT_ENTRIES / 2;

    // Inverse scale register, unsigned with 16 fraction bits.
    localparam int SCALE_BITS    = 24;

    // Fraction bits of an entry times the inverse scale.
    localparam int PROD_FRAC     = 24;

    // Table byte and its saturation limits.
    localparam int BYTE_BITS     = 8;
    localparam int INT8_MAX      = 127;
    localparam int INT8_MIN_MAG  = 128;

    // Result words.
    localparam int WORD_BITS     = HALF_ENTRIES * BYTE_BITS;
    localparam int BIAS_BITS     = 32;

endpackage : sslb_pkg

// ----- design/sslb_act_if.sv -----
// Input channel carrying one group of four activations and the first-group flag.
// Depends on sslb_pkg for the default activation width.
`timescale 1ns / 1ps

interface sslb_act_if import sslb_pkg::*; #(
    parameter int ACT_BITS = ACT_BITS_DEF
) ();

    logic                       valid;
    logic                       ready;
    logic signed [ACT_BITS-1:0] act_zero;
    logic signed [ACT_BITS-1:0] act_one;
    logic signed [ACT_BITS-1:0] act_two;
    logic signed [ACT_BITS-1:0] act_three;
    logic                       first_group;

    modport source (
        output valid,
        input  ready,
        output act_zero,
        output act_one,
        output act_two,
        output act_three,
        output first_group
    );

    modport sink (
        input  valid,
        output ready,
        input  act_zero,
        input  act_one,
        input  act_two,
        input  act_three,
        input  first_group
    );

endinterface : sslb_act_if

// ----- design/sslb_lut_if.sv -----
// Output channel carrying one packed int8 table and the running bias.
// Depends on sslb_pkg for the word widths.
`timescale 1ns / 1ps

interface sslb_lut_if import sslb_pkg::*; ();

    logic                        valid;
    logic                        ready;
    logic        [WORD_BITS-1:0] table_low;
    logic        [WORD_BITS-1:0] table_high;
    logic signed [BIAS_BITS-1:0] bias_total;

    modport source (
        output valid,
        input  ready,
        output table_low,
        output table_high,
        output bias_total
    );

    modport sink (
        input  valid,
        output ready,
        input  table_low,
        input  table_high,
        input  bias_total
    );

endinterface : sslb_lut_if

// ----- design/sslb_quant.sv -----
// Rounds one scaled table entry to nearest, ties to even, and saturates it to int8.
// Depends on sslb_pkg for the fraction width and the int8 limits.
`timescale 1ns / 1ps

module sslb_quant import sslb_pkg::*; #(
    parameter int PROD_BITS = 44
) (
    input  logic signed [PROD_BITS-1:0] prod,
    output logic        [BYTE_BITS-1:0] q_byte
);

    localparam int QUO_BITS = PROD_BITS - PROD_FRAC;

    logic                 neg;
    logic [PROD_BITS-1:0] mag;
    logic [QUO_BITS-1:0]  quo;
    logic [PROD_FRAC-1:0] rem;
    logic                 round_up;
    logic [QUO_BITS:0]    quo_rnd;

    // Rounding works on the magnitude so that it is symmetric about zero.
    always_comb
    begin
        neg      = prod[PROD_BITS-1];
        mag      = neg ? (~prod + PROD_BITS'(1)) : prod;
        quo      = mag[PROD_BITS-1:PROD_FRAC];
        rem      = mag[PROD_FRAC-1:0];
        round_up = (rem > {1'b1, {(PROD_FRAC-1){1'b0}}}) ||
                   ((rem == {1'b1, {(PROD_FRAC-1){1'b0}}}) && quo[0]);
        quo_rnd  = {1'b0, quo} + (QUO_BITS+1)'(round_up);

        if (neg)
        begin
            if (quo_rnd > (QUO_BITS+1)'(INT8_MIN_MAG))
            begin
                q_byte = BYTE_BITS'(INT8_MIN_MAG);
            end
            else
            begin
                q_byte = ~quo_rnd[BYTE_BITS-1:0] + BYTE_BITS'(1);
            end
        end
        else
        begin
            if (quo_rnd > (QUO_BITS+1)'(INT8_MAX))
            begin
                q_byte = BYTE_BITS'(INT8_MAX);
            end
            else
            begin
                q_byte = quo_rnd[BYTE_BITS-1:0];
            end
        end
    end

endmodule : sslb_quant

// ----- design/signed_sum_lut_builder_int8.sv -----
// Top level of the signed-sum lookup table builder (int8 table, groups of four).
// Depends on sslb_pkg, the sslb_act_if and sslb_lut_if channels and sslb_quant.
`timescale 1ns / 1ps

// The block takes one item per clock cycle, a group of four signed activations,
// and returns one item per group: a 16-entry int8 table packed into two 64-bit
// words plus the running bias. Entry g sums +a_i where bit i of g is set and
// -a_i where it is clear, is multiplied by the inverse scale register, rounded
// to nearest with ties to even and saturated to -128..127. The block sustains
// one item per cycle while lut_out.ready is high. Each item passes through a
// three-register pipeline: an input register, a stage of sixteen parallel
// entry multipliers, and a rounding stage feeding the output register. Each
// stage advances whenever the stage after it is empty or moving, so empty
// stages fill while a finished result waits to be taken. The bias accumulator
// adds the unscaled entry 0 of every group, saturating to 32 bits, and the
// first_group flag clears it before that add. The inverse scale register
// resets to zero, which makes every table byte zero; write it only while no
// item is in flight.
module signed_sum_lut_builder_int8 import sslb_pkg::*; #(
    parameter int ACT_BITS = ACT_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wr_en,
    input  logic [SCALE_BITS-1:0] cfg_wr_data,
    sslb_act_if.sink              act_in,
    sslb_lut_if.source            lut_out
);

    // An entry needs three bits over an activation: four terms, each of which
    // may be the negated most negative value.
    localparam int ENTRY_BITS = ACT_BITS + 3;
    localparam int PROD_BITS  = ENTRY_BITS + SCALE_BITS + 1;
    localparam int SUM_BITS   = ((ENTRY_BITS > BIAS_BITS) ? ENTRY_BITS : BIAS_BITS) + 1;

    // Configuration.
    logic [SCALE_BITS-1:0]        scale_reg;

    // Stage 0: registered input group.
    logic                         s0_valid_reg;
    logic signed [ACT_BITS-1:0]   act_reg [GROUP_SIZE];
    logic                         first_reg;

    // Stage 1: scaled entries and bias after this group.
    logic                         s1_valid_reg;
    logic signed [PROD_BITS-1:0]  prod_reg [LUT_ENTRIES];
    logic signed [BIAS_BITS-1:0]  bias1_reg;

    // Stage 2: output register.
    logic                         s2_valid_reg;
    logic [WORD_BITS-1:0]         tbl_low_reg;
    logic [WORD_BITS-1:0]         tbl_high_reg;
    logic signed [BIAS_BITS-1:0]  bias2_reg;

    // Running bias.
    logic signed [BIAS_BITS-1:0]  acc_reg;
    logic signed [BIAS_BITS-1:0]  acc_next;

    logic                         adv0;
    logic                         adv1;
    logic                         adv2;

    logic signed [ENTRY_BITS-1:0] entry      [LUT_ENTRIES];
    logic signed [PROD_BITS-1:0]  prod_next  [LUT_ENTRIES];
    logic [BYTE_BITS-1:0]         q_byte     [LUT_ENTRIES];
    logic [WORD_BITS-1:0]         tbl_low_next;
    logic [WORD_BITS-1:0]         tbl_high_next;
    logic signed [BIAS_BITS-1:0]  acc_base;
    logic signed [SUM_BITS-1:0]   acc_sum;

    // A stage moves when the next one is empty or moving itself.
    assign adv2         = !s2_valid_reg || lut_out.ready;
    assign adv1         = !s1_valid_reg || adv2;
    assign adv0         = !s0_valid_reg || adv1;
    assign act_in.ready = adv0;

    assign lut_out.valid      = s2_valid_reg;
    assign lut_out.table_low  = tbl_low_reg;
    assign lut_out.table_high = tbl_high_reg;
    assign lut_out.bias_total = bias2_reg;

    // Build the sixteen signed sums and scale each one in its own lane.
    for (genvar g = 0; g < LUT_ENTRIES; g++)
    begin : g_lane
        localparam logic [GROUP_SIZE-1:0] SEL = GROUP_SIZE'(g);

        always_comb
        begin
            entry[g] = '0;
            for (int i = 0; i < GROUP_SIZE; i++)
            begin
                if (SEL[i])
                begin
                    entry[g] = entry[g] + ENTRY_BITS'(act_reg[i]);
                end
                else
                begin
                    entry[g] = entry[g] - ENTRY_BITS'(act_reg[i]);
                end
            end
            prod_next[g] = PROD_BITS'(entry[g]) * $signed(PROD_BITS'(scale_reg));
        end

        sslb_quant #(
            .PROD_BITS (PROD_BITS)
        ) u_quant (
            .prod   (prod_reg[g]),
            .q_byte (q_byte[g])
        );
    end

    // Entry 0 lands in the lowest byte of the low word, entry 8 in the high word.
    always_comb
    begin
        for (int g = 0; g < HALF_ENTRIES; g++)
        begin
            tbl_low_next[g*BYTE_BITS +: BYTE_BITS]  = q_byte[g];
            tbl_high_next[g*BYTE_BITS +: BYTE_BITS] = q_byte[g + HALF_ENTRIES];
        end
    end

    // Bias update: the sum is one bit wider than either operand, so it is out
    // of range exactly when its top bits above the 32-bit sign do not agree.
    always_comb
    begin
        acc_base = first_reg ? '0 : acc_reg;
        acc_sum  = SUM_BITS'(acc_base) + SUM_BITS'(entry[0]);
        if ((&acc_sum[SUM_BITS-1:BIAS_BITS-1]) || !(|acc_sum[SUM_BITS-1:BIAS_BITS-1]))
        begin
            acc_next = acc_sum[BIAS_BITS-1:0];
        end
        else if (acc_sum[SUM_BITS-1])
        begin
            acc_next = {1'b1, {(BIAS_BITS-1){1'b0}}};
        end
        else
        begin
            acc_next = {1'b0, {(BIAS_BITS-1){1'b1}}};
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_reg    <= '0;
            acc_reg      <= '0;
            s0_valid_reg <= 1'b0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                scale_reg <= cfg_wr_data;
            end
            if (adv1 && s0_valid_reg)
            begin
                acc_reg <= acc_next;
            end
            if (adv0)
            begin
                s0_valid_reg <= act_in.valid;
            end
            if (adv1)
            begin
                s1_valid_reg <= s0_valid_reg;
            end
            if (adv2)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
        end
    end

    // Payload registers load only when an item moves into them.
    always_ff @(posedge clk)
    begin
        if (adv0 && act_in.valid)
        begin
            act_reg[0] <= act_in.act_zero;
            act_reg[1] <= act_in.act_one;
            act_reg[2] <= act_in.act_two;
            act_reg[3] <= act_in.act_three;
            first_reg  <= act_in.first_group;
        end
        if (adv1 && s0_valid_reg)
        begin
            prod_reg  <= prod_next;
            bias1_reg <= acc_next;
        end
        if (adv2 && s1_valid_reg)
        begin
            tbl_low_reg  <= tbl_low_next;
            tbl_high_reg <= tbl_high_next;
            bias2_reg    <= bias1_reg;
        end
    end

    // An empty input stage always takes a new item.
    a_ready_when_empty: assert property (
        @(posedge clk) disable iff (!rst_n)
        !s0_valid_reg |-> act_in.ready
    ) else $error("input refused while stage 0 is empty");

    // The bias moves only when a group leaves stage 0.
    a_acc_hold: assert property (
        @(posedge clk) disable iff (!rst_n)
        !(adv1 && s0_valid_reg) |=> $stable(acc_reg)
    ) else $error("bias accumulator changed without a group");

    // Entry 15 - g is the negation of entry g, and so are their products.
    a_prod_mirror: assert property (
        @(posedge clk) disable iff (!rst_n)
        s1_valid_reg |-> (prod_reg[0] == -prod_reg[LUT_ENTRIES-1])
    ) else $error("scaled entries 0 and 15 are not opposite");

    // A result appears only after an item sat in stage 1.
    a_out_source: assert property (
        @(posedge clk) disable iff (!rst_n)
        $rose(lut_out.valid) |-> $past(s1_valid_reg)
    ) else $error("result valid without an item in stage 1");

endmodule : signed_sum_lut_builder_int8
